### sv/twsbm_pkg.sv
// Shared types and codes for the three-wire serial byte master.
package twsbm_pkg;

   localparam int unsigned BitsPerByte = 8;
   localparam int unsigned PhaseWidth  = 4;
   localparam logic [PhaseWidth-1:0] LastBytePhase = 4'd15;
   localparam logic [7:0] HalfPeriodReset = 8'd48;

   typedef enum logic [1:0] {
      ACT_CE_RAISE = 2'd0,
      ACT_CE_DROP  = 2'd1,
      ACT_SEND     = 2'd2,
      ACT_RECEIVE  = 2'd3
   } action_type;

   typedef struct packed {
      logic                  load;
      logic                  emit;
      logic                  last;
      logic [PhaseWidth-1:0] phase;
   } cmd_type;

   typedef struct packed {
      logic is_ce;
      logic timer_done;
      logic slot_free;
   } status_type;

endpackage

### sv/three_wire_serial_byte_master_unit.sv
// Each phase beat is emitted once the phase timer runs out and the result register is free.
// A chip enable action yields one beat; a send or receive yields sixteen beats.
// Actions are taken one at a time, at a pace set by the phase timer;
// a new action is taken while the final beat still waits.
// Reset (synchronous): chip deselected, master drives the line low, half-period register 48.
module three_wire_serial_byte_master_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_action,
   input  logic [7:0] req_tx_byte,
   input  logic [7:0] req_line_bits,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_chip_enable,
   output logic       rsp_serial_clock,
   output logic       rsp_data_out,
   output logic       rsp_data_drive_enable,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_last
);

   twsbm_pkg::cmd_type    cmd;
   twsbm_pkg::status_type status;

   twsbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   twsbm_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_action            (req_action),
      .req_tx_byte           (req_tx_byte),
      .req_line_bits         (req_line_bits),
      .cmd                   (cmd),
      .status                (status),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_chip_enable       (rsp_chip_enable),
      .rsp_serial_clock      (rsp_serial_clock),
      .rsp_data_out          (rsp_data_out),
      .rsp_data_drive_enable (rsp_data_drive_enable),
      .rsp_rx_byte           (rsp_rx_byte),
      .rsp_last              (rsp_last)
   );

endmodule

### sv/twsbm_ctrl.sv
// Phase sequencer: accepts actions and steps through their pin phases.
module twsbm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  twsbm_pkg::status_type  status,
   output twsbm_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PHASE = 2'b10
   } state_type;

   state_type                          state_ff, state_in;
   logic [twsbm_pkg::PhaseWidth-1:0]   phase_ff, phase_in;
   logic                               last_phase;
   logic                               emit;

   assign last_phase = status.is_ce || (phase_ff == twsbm_pkg::LastBytePhase);
   assign emit       = (state_ff == ST_PHASE) && status.timer_done && status.slot_free;
   assign req_stall  = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PHASE;
               phase_in = '0;
            end
         end
         ST_PHASE: begin
            if (emit) begin
               phase_in = phase_ff + 1'b1;
               if (last_phase) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      cmd.load  = (state_ff == ST_IDLE) && req_valid;
      cmd.emit  = emit;
      cmd.last  = last_phase;
      cmd.phase = phase_ff;
   end

endmodule

### sv/twsbm_dp.sv
// Datapath: pin state, shift register, phase timer and result register.
module twsbm_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_tx_byte,
   input  logic [7:0]            req_line_bits,
   input  twsbm_pkg::cmd_type    cmd,
   output twsbm_pkg::status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_chip_enable,
   output logic                  rsp_serial_clock,
   output logic                  rsp_data_out,
   output logic                  rsp_data_drive_enable,
   output logic [7:0]            rsp_rx_byte,
   output logic                  rsp_last
);

   logic [7:0] half_period_ff;
   logic [7:0] timer_ff;
   logic       enable_ff, enable_in;
   logic       drive_en_ff, drive_en_in;
   logic       drive_lvl_ff, drive_lvl_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] line_ff;
   twsbm_pkg::action_type action_ff;
   logic       valid_ff;
   logic       chip_enable_ff;
   logic       serial_clock_ff;
   logic       data_out_ff;
   logic       data_drive_en_ff;
   logic [7:0] rx_byte_ff;
   logic       last_ff;
   logic       high_phase;
   logic [2:0] bit_idx;
   logic       is_ce;

   assign is_ce      = (action_ff == twsbm_pkg::ACT_CE_RAISE) ||
                       (action_ff == twsbm_pkg::ACT_CE_DROP);
   assign bit_idx    = cmd.phase[3:1];
   assign high_phase = !is_ce && !cmd.phase[0];

   always_comb begin
      status.is_ce      = is_ce;
      status.timer_done = (timer_ff <= 8'd1);
      status.slot_free  = !valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= twsbm_pkg::HalfPeriodReset;
      end else if (csr_write_enable) begin
         half_period_ff <= csr_write_data;
      end
   end

   // reload at the start of every phase, count down to one
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= twsbm_pkg::HalfPeriodReset;
      end else if (cmd.load || cmd.emit) begin
         timer_ff <= half_period_ff;
      end else if (!status.timer_done) begin
         timer_ff <= timer_ff - 8'd1;
      end
   end

   always_comb begin
      enable_in    = enable_ff;
      drive_en_in  = drive_en_ff;
      drive_lvl_in = drive_lvl_ff;
      shift_in     = shift_ff;
      if (cmd.load) begin
         unique case (twsbm_pkg::action_type'(req_action))
            twsbm_pkg::ACT_CE_RAISE: enable_in = 1'b1;
            twsbm_pkg::ACT_CE_DROP:  enable_in = 1'b0;
            twsbm_pkg::ACT_SEND: begin
               drive_en_in = 1'b1;
               shift_in    = req_tx_byte;
            end
            twsbm_pkg::ACT_RECEIVE: begin
               drive_en_in = 1'b0;
               shift_in    = '0;
            end
            default: enable_in = enable_ff;
         endcase
      end else if (cmd.emit && high_phase) begin
         // drive the next bit, or sample the line, in the beat that raises the serial clock
         if (action_ff == twsbm_pkg::ACT_SEND) begin
            drive_lvl_in = shift_ff[bit_idx];
         end else begin
            shift_in[bit_idx] = line_ff[bit_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         drive_en_ff  <= 1'b1;
         drive_lvl_ff <= 1'b0;
         shift_ff     <= '0;
         action_ff    <= twsbm_pkg::ACT_CE_DROP;
      end else begin
         enable_ff    <= enable_in;
         drive_en_ff  <= drive_en_in;
         drive_lvl_ff <= drive_lvl_in;
         shift_ff     <= shift_in;
         if (cmd.load) action_ff <= twsbm_pkg::action_type'(req_action);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) line_ff <= req_line_bits;
   end

   // result register: hold a beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         chip_enable_ff   <= enable_in;
         serial_clock_ff  <= high_phase;
         data_out_ff      <= drive_lvl_in;
         data_drive_en_ff <= drive_en_in;
         rx_byte_ff       <= (cmd.last && action_ff == twsbm_pkg::ACT_RECEIVE) ?
                             shift_in : 8'd0;
         last_ff          <= cmd.last;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_chip_enable       = chip_enable_ff;
   assign rsp_serial_clock      = serial_clock_ff;
   assign rsp_data_out          = data_out_ff;
   assign rsp_data_drive_enable = data_drive_en_ff;
   assign rsp_rx_byte           = rx_byte_ff;
   assign rsp_last              = last_ff;

endmodule

### sim/three_wire_serial_byte_master_unit_tb.sv
// Self-checking bench for the three-wire serial byte master: pin phases vs. a local predictor.
module three_wire_serial_byte_master_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QuietLimit = 20000;

   typedef struct packed {
      logic       ce;
      logic       sclk;
      logic       dout;
      logic       den;
      logic [7:0] rx;
      logic       last;
   } pin_phase_type;

   typedef struct packed {
      twsbm_pkg::action_type act;
      logic [7:0] tx;
      logic [7:0] line;
      logic       typed;
      logic       ce;
      logic       dout;
      logic       den;
      logic [7:0] rx;
   } directed_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_action = twsbm_pkg::ACT_CE_DROP;
   logic [7:0] req_tx_byte = 8'd0;
   logic [7:0] req_line_bits = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_chip_enable;
   logic       rsp_serial_clock;
   logic       rsp_data_out;
   logic       rsp_data_drive_enable;
   logic [7:0] rsp_rx_byte;
   logic       rsp_last;

   three_wire_serial_byte_master_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_tx_byte           (req_tx_byte),
      .req_line_bits         (req_line_bits),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_chip_enable       (rsp_chip_enable),
      .rsp_serial_clock      (rsp_serial_clock),
      .rsp_data_out          (rsp_data_out),
      .rsp_data_drive_enable (rsp_data_drive_enable),
      .rsp_rx_byte           (rsp_rx_byte),
      .rsp_last              (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pin state as the master should hold it
   logic       pin_ce;
   logic       pin_drive_en;
   logic       pin_drive_lvl;
   logic [7:0] pin_shift;
   int         period_shadow;

   pin_phase_type    phases_due[$];
   directed_row_type dir_rows[20];
   int               mismatches = 0;
   int               items_sent = 0;
   logic             idle_enable = 1'b1;
   int unsigned      quiet_cycles = 0;

   task automatic push_phase(input logic sclk, input logic [7:0] rx, input logic fin,
                             input logic typed, input pin_phase_type typed_last);
      pin_phase_type ph;
      ph = '{pin_ce, sclk, pin_drive_lvl, pin_drive_en, rx, fin};
      if (fin && typed) begin
         ph = typed_last;
      end
      phases_due.push_back(ph);
   endtask

   task automatic predict_phases(input twsbm_pkg::action_type act, input logic [7:0] tx,
                                 input logic [7:0] line, input logic typed,
                                 input pin_phase_type typed_last);
      case (act) inside
         twsbm_pkg::ACT_CE_RAISE, twsbm_pkg::ACT_CE_DROP: begin
            pin_ce = (act == twsbm_pkg::ACT_CE_RAISE);
            push_phase(1'b0, 8'd0, 1'b1, typed, typed_last);
         end
         twsbm_pkg::ACT_SEND: begin
            pin_drive_en = 1'b1;
            pin_shift = tx;
            for (int i = 0; i < twsbm_pkg::BitsPerByte; i++) begin
               pin_drive_lvl = tx[i];
               push_phase(1'b1, 8'd0, 1'b0, typed, typed_last);
               push_phase(1'b0, 8'd0, i == twsbm_pkg::BitsPerByte - 1, typed, typed_last);
            end
         end
         default: begin
            pin_drive_en = 1'b0;
            pin_shift = 8'd0;
            for (int i = 0; i < twsbm_pkg::BitsPerByte; i++) begin
               pin_shift[i] = line[i];
               push_phase(1'b1, 8'd0, 1'b0, typed, typed_last);
               if (i == twsbm_pkg::BitsPerByte - 1) begin
                  push_phase(1'b0, pin_shift, 1'b1, typed, typed_last);
               end else begin
                  push_phase(1'b0, 8'd0, 1'b0, typed, typed_last);
               end
            end
         end
      endcase
   endtask

   task automatic report_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      pin_phase_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (phases_due.size() == 0) begin
               $display("%0t: beat with nothing expected, ce %0b sclk %0b last %0b", $time,
                        rsp_chip_enable, rsp_serial_clock, rsp_last);
               mismatches++;
            end else begin
               want = phases_due.pop_front();
               report_field("chip_enable", want.ce, rsp_chip_enable);
               report_field("serial_clock", want.sclk, rsp_serial_clock);
               report_field("data_out", want.dout, rsp_data_out);
               report_field("data_drive_enable", want.den, rsp_data_drive_enable);
               report_field("rx_byte", want.rx, rsp_rx_byte);
               report_field("last", want.last, rsp_last);
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QuietLimit) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         rsp_stall <= idle_enable && ($urandom_range(99) < 22);
      end
   end

   task automatic send_action(input twsbm_pkg::action_type act, input logic [7:0] tx,
                              input logic [7:0] line, input logic typed,
                              input pin_phase_type typed_last);
      while (idle_enable && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_tx_byte <= tx;
      req_line_bits <= line;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_phases(act, tx, line, typed, typed_last);
      items_sent++;
   endtask

   task automatic send_random(input twsbm_pkg::action_type act);
      send_action(act, 8'($urandom), 8'($urandom), 1'b0, '0);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (phases_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_period(input logic [7:0] cycles);
      hold_until_drained();
      // let the final phase timer run out before touching the register
      repeat (period_shadow + 8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= cycles;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      period_shadow = cycles;
   endtask

   task automatic run_random(input int count);
      int target;
      int midpoint;
      logic paused;
      target = items_sent + count;
      midpoint = items_sent + count / 2;
      paused = 1'b0;
      while (items_sent < target) begin
         if (!paused && items_sent >= midpoint) begin
            hold_until_drained();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 80) begin
            // select, command byte, a few data bytes, deselect
            send_random(twsbm_pkg::ACT_CE_RAISE);
            send_random(twsbm_pkg::ACT_SEND);
            repeat ($urandom_range(1, 3)) begin
               send_random($urandom_range(1) ? twsbm_pkg::ACT_RECEIVE
                                             : twsbm_pkg::ACT_SEND);
            end
            send_random(twsbm_pkg::ACT_CE_DROP);
         end else begin
            send_random(twsbm_pkg::action_type'($urandom_range(3)));
         end
      end
   endtask

   initial begin
      pin_ce = 1'b0;
      pin_drive_en = 1'b1;
      pin_drive_lvl = 1'b0;
      pin_shift = 8'd0;
      period_shadow = twsbm_pkg::HalfPeriodReset;

      dir_rows[0]  = '{twsbm_pkg::ACT_RECEIVE, 8'h00, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b0, 8'hA5};
      dir_rows[1]  = '{twsbm_pkg::ACT_CE_RAISE, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
      dir_rows[2]  = '{twsbm_pkg::ACT_SEND, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00};
      dir_rows[3]  = '{twsbm_pkg::ACT_SEND, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00};
      dir_rows[4]  = '{twsbm_pkg::ACT_RECEIVE, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
      dir_rows[5]  = '{twsbm_pkg::ACT_RECEIVE, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 8'hFF};
      dir_rows[6]  = '{twsbm_pkg::ACT_CE_RAISE, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
      dir_rows[7]  = '{twsbm_pkg::ACT_CE_DROP, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00};
      dir_rows[8]  = '{twsbm_pkg::ACT_CE_DROP, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00};
      dir_rows[9]  = '{twsbm_pkg::ACT_SEND, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[10] = '{twsbm_pkg::ACT_SEND, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[11] = '{twsbm_pkg::ACT_CE_RAISE, 8'h5A, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[12] = '{twsbm_pkg::ACT_RECEIVE, 8'hFF, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[13] = '{twsbm_pkg::ACT_SEND, 8'h7F, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[14] = '{twsbm_pkg::ACT_SEND, 8'hA5, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[15] = '{twsbm_pkg::ACT_RECEIVE, 8'h00, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[16] = '{twsbm_pkg::ACT_RECEIVE, 8'h00, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[17] = '{twsbm_pkg::ACT_CE_DROP, 8'h3C, 8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[18] = '{twsbm_pkg::ACT_SEND, 8'h3C, 8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
      dir_rows[19] = '{twsbm_pkg::ACT_CE_RAISE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_action(dir_rows[i].act, dir_rows[i].tx, dir_rows[i].line, dir_rows[i].typed,
                     '{dir_rows[i].ce, 1'b0, dir_rows[i].dout, dir_rows[i].den,
                       dir_rows[i].rx, 1'b1});
      end

      set_period(8'd1);
      run_random(120);
      set_period(8'd255);
      run_random(4);
      set_period(8'd2);
      idle_enable = 1'b0;
      run_random(80);
      idle_enable = 1'b1;
      set_period(8'($urandom_range(3, 8)));
      run_random(80);
      set_period(8'($urandom_range(9, 40)));
      run_random(56);

      hold_until_drained();
      repeat (2 * period_shadow + 16) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sim.f
sv/twsbm_pkg.sv
sv/twsbm_ctrl.sv
sv/twsbm_dp.sv
sv/three_wire_serial_byte_master_unit.sv
sim/three_wire_serial_byte_master_unit_tb.sv
